// File: rtl/core/arpc_pkg.sv
// shared constants, codes and widths of the arp cache and responder
`default_nettype none

package arpc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int IP_W = 32;
    localparam int MAC_W = 48;
    localparam int ENTRY_W = IP_W + MAC_W;

    localparam int IN_TDATA_W = 160;
    localparam int OUT_FIELDS_W = 244;
    localparam int OUT_TDATA_W = 248;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_OWN_IP = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_OWN_MAC = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_REQ_SRC_IP = 2'd2;

    localparam logic [IP_W-1:0] REQ_SRC_IP_RST = {8'd10, 8'd0, 8'd2, 8'd15};
    localparam logic [MAC_W-1:0] MAC_BROADCAST = {MAC_W{1'b1}};

    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY = 16'd2;

    localparam logic [1:0] TXOP_NONE = 2'd0;
    localparam logic [1:0] TXOP_REQUEST = 2'd1;
    localparam logic [1:0] TXOP_REPLY = 2'd2;

    localparam logic [2:0] ST_HIT = 3'd0;
    localparam logic [2:0] ST_PENDING = 3'd1;
    localparam logic [2:0] ST_REQ_SENT = 3'd2;
    localparam logic [2:0] ST_REPLY_SENT = 3'd3;
    localparam logic [2:0] ST_RESOLVED = 3'd4;
    localparam logic [2:0] ST_ADDED = 3'd5;
    localparam logic [2:0] ST_IGNORED = 3'd6;
    localparam logic [2:0] ST_UNKNOWN_OP = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } seq_state_t;

endpackage

`default_nettype wire

// File: rtl/core/arp_cache_and_responder.sv
// top level of the arp cache and responder
//
// input words arrive on the s_axis channel: tuser carries the command (0 lookup,
// 1 received arp packet), tdata the lookup address and the received packet fields.
// one result word leaves on the m_axis channel for every input word: tuser holds
// the status, tdata the table full flag, found mac, entry address and the fields
// of an arp frame to transmit when tx_valid is set.
// a lookup or a received reply walks the table once through a single address
// comparator, one entry per cycle out of the entry ram, and stops early on a hit.
// a received request or an unknown opcode skips the walk and goes straight to the
// finish state.
// one word is worked on at a time; s_axis_tready is high only while idle, so a new
// word is taken only after the last one has left the finish state.
// a finished result waits in the output register while the receiver stalls,
// the next word may be accepted meanwhile but holds before its result is stored.
// reset empties the table (valid and resolved bits cleared), clears the output valid
// flag and sets the config registers to their defaults; no clearing pass is needed.
// config registers are written over apb at byte addresses 0, 8 and 16.
`default_nettype none

module arp_cache_and_responder (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // query_ip, opcode, sender_ip, sender_mac, target_ip
    input  wire logic [arpc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // cmd
    input  wire logic                                  s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // table_full, found_mac, entry_ip, tx_valid, tx_opcode, tx_frame_dest_mac,
    // tx_target_mac, tx_target_ip, tx_sender_ip, zero pad
    output logic      [arpc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // status
    output logic      [2:0]                            m_axis_tuser,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [arpc_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [arpc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic      [arpc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                       pready
);

    import arpc_pkg::*;

    // config registers
    logic [IP_W-1:0]  own_ip_reg;
    logic [MAC_W-1:0] own_mac_reg;
    logic [IP_W-1:0]  req_src_ip_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic cfg_we;

    // sequencer
    seq_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic found_reg, found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [MAC_W-1:0] hit_mac_reg, hit_mac_next;
    logic free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] resolved_reg, resolved_next;
    logic out_valid_reg, out_valid_next;

    // latched input word
    logic cmd_reg;
    logic is_req_reg;
    logic is_rep_reg;
    logic [IP_W-1:0] key_ip_reg;
    logic [MAC_W-1:0] smac_reg;
    logic [IP_W-1:0] tip_reg;

    // output register
    logic [2:0] out_status_reg;
    logic [OUT_FIELDS_W-1:0] out_fields_reg;

    // entry ram
    logic ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [IP_W-1:0] rd_ip;
    logic [MAC_W-1:0] rd_mac;

    // shared comparator
    logic [IP_W-1:0] cmp_a;
    logic [IP_W-1:0] cmp_b;
    logic cmp_eq;

    logic in_accept;
    logic advance;
    logic in_cmd;
    logic in_is_rep;
    logic in_is_req;

    // finish stage result
    logic [2:0] res_status;
    logic res_full;
    logic [MAC_W-1:0] res_mac;
    logic res_tx_valid;
    logic [1:0] res_tx_op;
    logic [MAC_W-1:0] res_dmac;
    logic [MAC_W-1:0] res_tmac;
    logic [IP_W-1:0] res_tip;
    logic [IP_W-1:0] res_sip;
    logic res_we;
    logic [IDX_W-1:0] res_widx;
    logic [MAC_W-1:0] res_wmac;
    logic res_set_valid;
    logic res_set_resolved;

    arpc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_ip = ram_rdata[ENTRY_W-1:MAC_W];
    assign rd_mac = ram_rdata[MAC_W-1:0];

    // apb port
    assign pready = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx)
            REG_OWN_IP:     prdata = {{(APB_DATA_W - IP_W){1'b0}}, own_ip_reg};
            REG_OWN_MAC:    prdata = {{(APB_DATA_W - MAC_W){1'b0}}, own_mac_reg};
            REG_REQ_SRC_IP: prdata = {{(APB_DATA_W - IP_W){1'b0}}, req_src_ip_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
            own_mac_reg <= '0;
            req_src_ip_reg <= REQ_SRC_IP_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx)
                REG_OWN_IP:     own_ip_reg <= pwdata[IP_W-1:0];
                REG_OWN_MAC:    own_mac_reg <= pwdata[MAC_W-1:0];
                REG_REQ_SRC_IP: req_src_ip_reg <= pwdata[IP_W-1:0];
                default:        ;
            endcase
        end
    end

    // handshakes
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign advance = (state_reg == S_FINISH) && (!out_valid_reg || m_axis_tready);
    assign in_cmd = s_axis_tuser;
    assign in_is_rep = (s_axis_tdata[47:32] == ARP_OP_REPLY);
    assign in_is_req = (s_axis_tdata[47:32] == ARP_OP_REQUEST);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser = out_status_reg;
    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_fields_reg};

    // comparator: table address against key while scanning, else request target
    assign cmp_a = (state_reg == S_SCAN) ? rd_ip : own_ip_reg;
    assign cmp_b = (state_reg == S_SCAN) ? key_ip_reg : tip_reg;
    assign cmp_eq = (cmp_a == cmp_b);

    assign ram_raddr = cnt_reg[IDX_W-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        found_next = found_reg;
        hit_idx_next = hit_idx_reg;
        hit_mac_next = hit_mac_reg;
        free_found_next = free_found_reg;
        free_idx_next = free_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cnt_next = '0;
                    cmp_vld_next = 1'b0;
                    found_next = 1'b0;
                    free_found_next = 1'b0;
                    if (!in_cmd || in_is_rep)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                cmp_vld_next = (cnt_reg < CNT_W'(TABLE_DEPTH));
                cmp_idx_next = cnt_reg[IDX_W-1:0];
                if (cnt_reg < CNT_W'(TABLE_DEPTH))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    if (valid_reg[cmp_idx_reg] && cmp_eq)
                    begin
                        found_next = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        hit_mac_next = rd_mac;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == IDX_W'(TABLE_DEPTH - 1))
                        begin
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_FINISH:
            begin
                if (advance)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result and table update
    always_comb
    begin
        res_status = ST_IGNORED;
        res_full = 1'b0;
        res_mac = '0;
        res_tx_valid = 1'b0;
        res_tx_op = TXOP_NONE;
        res_dmac = '0;
        res_tmac = '0;
        res_tip = '0;
        res_sip = '0;
        res_we = 1'b0;
        res_widx = free_idx_reg;
        res_wmac = '0;
        res_set_valid = 1'b0;
        res_set_resolved = 1'b0;
        if (!cmd_reg)
        begin
            if (found_reg)
            begin
                if (resolved_reg[hit_idx_reg])
                begin
                    res_status = ST_HIT;
                    res_mac = hit_mac_reg;
                end
                else
                begin
                    res_status = ST_PENDING;
                end
            end
            else if (free_found_reg)
            begin
                res_status = ST_REQ_SENT;
                res_we = 1'b1;
                res_set_valid = 1'b1;
                res_set_resolved = 1'b0;
                res_tx_valid = 1'b1;
                res_tx_op = TXOP_REQUEST;
                res_dmac = MAC_BROADCAST;
                res_tip = key_ip_reg;
                res_sip = req_src_ip_reg;
            end
            else
            begin
                res_status = ST_IGNORED;
                res_full = 1'b1;
            end
        end
        else if (is_req_reg)
        begin
            if (cmp_eq)
            begin
                res_status = ST_REPLY_SENT;
                res_tx_valid = 1'b1;
                res_tx_op = TXOP_REPLY;
                res_dmac = smac_reg;
                res_tmac = smac_reg;
                res_tip = key_ip_reg;
                res_sip = own_ip_reg;
            end
            else
            begin
                res_status = ST_IGNORED;
            end
        end
        else if (is_rep_reg)
        begin
            if (found_reg)
            begin
                res_status = ST_RESOLVED;
                res_mac = smac_reg;
                res_we = 1'b1;
                res_widx = hit_idx_reg;
                res_wmac = smac_reg;
                res_set_valid = 1'b1;
                res_set_resolved = 1'b1;
            end
            else if (free_found_reg)
            begin
                res_status = ST_ADDED;
                res_mac = smac_reg;
                res_we = 1'b1;
                res_wmac = smac_reg;
                res_set_valid = 1'b1;
                res_set_resolved = 1'b1;
            end
            else
            begin
                res_status = ST_IGNORED;
                res_full = 1'b1;
            end
        end
        else
        begin
            res_status = ST_UNKNOWN_OP;
        end
    end

    assign ram_we = advance && res_we;
    assign ram_waddr = res_widx;
    assign ram_wdata = {key_ip_reg, res_wmac};

    always_comb
    begin
        valid_next = valid_reg;
        resolved_next = resolved_reg;
        if (advance && res_set_valid)
        begin
            valid_next[res_widx] = 1'b1;
            resolved_next[res_widx] = res_set_resolved;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_idx_reg <= '0;
            found_reg <= 1'b0;
            hit_idx_reg <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg <= '0;
            valid_reg <= '0;
            resolved_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            cmp_idx_reg <= cmp_idx_next;
            found_reg <= found_next;
            hit_idx_reg <= hit_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg <= free_idx_next;
            valid_reg <= valid_next;
            resolved_reg <= resolved_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hit_mac_reg <= hit_mac_next;
        if (in_accept)
        begin
            cmd_reg <= in_cmd;
            is_req_reg <= in_is_req;
            is_rep_reg <= in_is_rep;
            key_ip_reg <= in_cmd ? s_axis_tdata[79:48] : s_axis_tdata[31:0];
            smac_reg <= s_axis_tdata[127:80];
            tip_reg <= s_axis_tdata[159:128];
        end
        if (advance)
        begin
            out_status_reg <= res_status;
            out_fields_reg <= {res_sip, res_tip, res_tmac, res_dmac, res_tx_op,
                               res_tx_valid, key_ip_reg, res_mac, res_full};
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/arpc_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/arpc_checker.sv
// port-level checks of the arp cache and responder, bound to the top level
`default_nettype none

module arpc_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [arpc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input wire logic [2:0]                          m_axis_tuser
);

    import arpc_pkg::*;

    // a frame goes out only with a request or a reply
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[81]
        |-> (m_axis_tuser == ST_REQ_SENT) || (m_axis_tuser == ST_REPLY_SENT))
        else $error("tx_valid with a status that sends nothing");

    // no frame means all frame fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[81] |-> (m_axis_tdata[243:82] == 162'd0))
        else $error("frame fields set without tx_valid");

    // a full table is only reported with an ignored status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> (m_axis_tuser == ST_IGNORED))
        else $error("table_full with a status other than ignored");

    // the block is busy right after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready again right after acceptance");

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

endmodule

bind arp_cache_and_responder arpc_checker u_arpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
